// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- sv/ffha_pkg.sv -----
// Package with shared types and constants of the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StZero    = 3'd1;
  localparam logic [2:0] StNoSpace = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StUnknown = 3'd4;

  localparam logic [16:0] MinAlloc = 17'd16;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_MERGE_LO, S_DROP_LO, S_MERGE_HI, S_DROP_HI, S_TRIM, S_DONE
  } state_e;

  // Command broadcast to all cells of the row
  typedef enum logic [2:0] {
    C_NONE, C_INSERT, C_DELETE, C_WRITE, C_SETUSED
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [5:0]  pos;
    logic [15:0] start_val;
    logic [15:0] size_val;
    logic        used_val;
  } cell_ctl_t;
endpackage

// ----- sv/ffha_cell.sv -----
// One table cell: holds one block entry and shifts with its neighbors
`timescale 1ns / 1ps
module ffha_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                clk_i,
  input  ffha_pkg::cell_ctl_t ctl_i,
  input  logic [15:0]         prev_start_i,
  input  logic [15:0]         prev_size_i,
  input  logic                prev_used_i,
  input  logic [15:0]         next_start_i,
  input  logic [15:0]         next_size_i,
  input  logic                next_used_i,
  output logic [15:0]         start_o,
  output logic [15:0]         size_o,
  output logic                used_o
);
  localparam logic [5:0] MyIdx = 6'(Idx);
  logic [15:0] start_q, start_d, size_q, size_d;
  logic        used_q, used_d;

  always_comb begin
    start_d = start_q;
    size_d  = size_q;
    used_d  = used_q;
    unique case (ctl_i.cmd)
      ffha_pkg::C_INSERT: begin
        // entries above pos move up one, pos takes the new entry
        if (MyIdx > ctl_i.pos) begin
          start_d = prev_start_i;
          size_d  = prev_size_i;
          used_d  = prev_used_i;
        end else if (MyIdx == ctl_i.pos) begin
          start_d = ctl_i.start_val;
          size_d  = ctl_i.size_val;
          used_d  = ctl_i.used_val;
        end
      end
      ffha_pkg::C_DELETE: begin
        if (MyIdx >= ctl_i.pos) begin
          start_d = next_start_i;
          size_d  = next_size_i;
          used_d  = next_used_i;
        end
      end
      ffha_pkg::C_WRITE: begin
        if (MyIdx == ctl_i.pos) begin
          start_d = ctl_i.start_val;
          size_d  = ctl_i.size_val;
          used_d  = ctl_i.used_val;
        end
      end
      ffha_pkg::C_SETUSED: begin
        if (MyIdx == ctl_i.pos) used_d = ctl_i.used_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    size_q  <= size_d;
    used_q  <= used_d;
  end

  assign start_o = start_q;
  assign size_o  = size_q;
  assign used_o  = used_q;
endmodule

// ----- sv/first_fit_heap_allocator_unit.sv -----
// A plain allocate, a failed request or a null or unknown free passes the decide state only;
// a split allocate adds a trim state, and a free adds the merge and drop states.
// One request at a time: the input stalls until the result has been taken.
// The search compares all cells at once and picks the first hit by priority;
// inserts and deletes shift every cell from the given position upward by one place.
// Reset clears the block count and the break; table cells hold no reset value.
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit #(
  parameter int unsigned HeapBytes   = 65536,
  parameter int unsigned MaxBlocks   = 64,
  parameter int unsigned HeaderBytes = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] payload_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] granted_address_o,
  output logic [2:0]  status_o
);
  localparam int unsigned IW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam logic [16:0] Hdr  = 17'(HeaderBytes);
  localparam logic [17:0] Heap = 18'(HeapBytes);
  localparam logic [6:0]  Max  = 7'(MaxBlocks);

  logic [15:0] cs [MaxBlocks];
  logic [15:0] cz [MaxBlocks];
  logic        cu [MaxBlocks];
  ffha_pkg::cell_ctl_t ctl;

  for (genvar g = 0; g < MaxBlocks; g++) begin : g_cell
    ffha_cell #(.Idx(g)) u_cell (
      .clk_i,
      .ctl_i        (ctl),
      .prev_start_i (cs[(g == 0) ? 0 : g - 1]),
      .prev_size_i  (cz[(g == 0) ? 0 : g - 1]),
      .prev_used_i  (cu[(g == 0) ? 0 : g - 1]),
      .next_start_i (cs[(g == MaxBlocks - 1) ? g : g + 1]),
      .next_size_i  (cz[(g == MaxBlocks - 1) ? g : g + 1]),
      .next_used_i  (cu[(g == MaxBlocks - 1) ? g : g + 1]),
      .start_o      (cs[g]),
      .size_o       (cz[g]),
      .used_o       (cu[g])
    );
  end

  ffha_pkg::state_e state_q, state_d;
  logic [6:0]  count_q, count_d;
  logic [16:0] brk_q, brk_d;
  logic        func_q;
  logic [16:0] size_q;
  logic [15:0] addr_q;
  logic [IW-1:0] idx_q, idx_d;
  logic [15:0] gaddr_q, gaddr_d;
  logic [2:0]  st_q, st_d;

  // rounded request; zero stays zero so it can be flagged
  logic [16:0] rsize;
  always_comb begin
    if (request_size_i == 16'd0) rsize = '0;
    else if (request_size_i < 16'd16) rsize = ffha_pkg::MinAlloc;
    else rsize = (17'(request_size_i) + 17'd7) & ~17'd7;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      func_q <= func_i;
      size_q <= rsize;
      addr_q <= payload_address_i;
    end
  end

  // parallel match over cells with priority pick
  logic            fit_hit, adr_hit;
  logic [IW-1:0]   fit_idx, adr_idx;
  always_comb begin
    fit_hit = 1'b0; fit_idx = '0;
    adr_hit = 1'b0; adr_idx = '0;
    for (int k = MaxBlocks - 1; k >= 0; k--) begin
      if (7'(k) < count_q) begin
        if (!cu[k] && 17'(cz[k]) >= size_q) begin
          fit_hit = 1'b1; fit_idx = IW'(k);
        end
        if (17'(cs[k]) + Hdr == 17'(addr_q)) begin
          adr_hit = 1'b1; adr_idx = IW'(k);
        end
      end
    end
  end

  logic [6:0] idx7;
  assign idx7 = 7'(idx_q);
  logic [IW-1:0] idxm1, idxp1;
  assign idxm1 = idx_q - IW'(1);
  assign idxp1 = idx_q + IW'(1);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    brk_d   = brk_q;
    idx_d   = idx_q;
    gaddr_d = gaddr_q;
    st_d    = st_q;
    ctl     = '0;
    ctl.cmd = ffha_pkg::C_NONE;
    unique case (state_q)
      ffha_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ffha_pkg::S_DECIDE;
      end
      ffha_pkg::S_DECIDE: begin
        state_d = ffha_pkg::S_DONE;
        gaddr_d = '0;
        st_d    = ffha_pkg::StOk;
        if (!func_q) begin
          if (size_q == 17'd0) begin
            st_d = ffha_pkg::StZero;
          end else if (fit_hit) begin
            gaddr_d = 16'(17'(cs[fit_idx]) + Hdr);
            if (17'(cz[fit_idx]) > size_q + Hdr && count_q < Max) begin
              // remainder goes in as a free block above the hit, hit is trimmed next
              ctl.cmd       = ffha_pkg::C_INSERT;
              ctl.pos       = 6'(fit_idx + IW'(1));
              ctl.start_val = 16'(17'(cs[fit_idx]) + Hdr + size_q);
              ctl.size_val  = 16'(17'(cz[fit_idx]) - size_q - Hdr);
              ctl.used_val  = 1'b0;
              count_d = count_q + 7'd1;
              idx_d   = fit_idx;
              state_d = ffha_pkg::S_TRIM;
            end else begin
              ctl.cmd      = ffha_pkg::C_SETUSED;
              ctl.pos      = 6'(fit_idx);
              ctl.used_val = 1'b1;
            end
          end else if (18'(brk_q) + 18'(Hdr) + 18'(size_q) > Heap) begin
            st_d = ffha_pkg::StNoSpace;
          end else if (count_q >= Max) begin
            st_d = ffha_pkg::StFull;
          end else begin
            ctl.cmd       = ffha_pkg::C_WRITE;
            ctl.pos       = 6'(count_q);
            ctl.start_val = 16'(brk_q);
            ctl.size_val  = 16'(size_q);
            ctl.used_val  = 1'b1;
            count_d = count_q + 7'd1;
            brk_d   = brk_q + Hdr + size_q;
            gaddr_d = 16'(brk_q + Hdr);
          end
        end else if (addr_q != 16'd0) begin
          if (!adr_hit) begin
            st_d = ffha_pkg::StUnknown;
          end else begin
            ctl.cmd      = ffha_pkg::C_SETUSED;
            ctl.pos      = 6'(adr_idx);
            ctl.used_val = 1'b0;
            idx_d   = adr_idx;
            state_d = ffha_pkg::S_MERGE_LO;
          end
        end
      end
      ffha_pkg::S_TRIM: begin
        ctl.cmd       = ffha_pkg::C_WRITE;
        ctl.pos       = 6'(idx_q);
        ctl.start_val = cs[idx_q];
        ctl.size_val  = 16'(size_q);
        ctl.used_val  = 1'b1;
        state_d = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_MERGE_LO: begin
        state_d = ffha_pkg::S_MERGE_HI;
        if (idx_q != '0 && !cu[idxm1]) begin
          ctl.cmd       = ffha_pkg::C_WRITE;
          ctl.pos       = 6'(idxm1);
          ctl.start_val = cs[idxm1];
          ctl.size_val  = 16'(17'(cz[idxm1]) + Hdr + 17'(cz[idx_q]));
          ctl.used_val  = 1'b0;
          idx_d   = idxm1;
          state_d = ffha_pkg::S_DROP_LO;
        end
      end
      ffha_pkg::S_DROP_LO: begin
        // the freed block sits right above the grown lower neighbor
        ctl.cmd = ffha_pkg::C_DELETE;
        ctl.pos = 6'(idxp1);
        count_d = count_q - 7'd1;
        state_d = ffha_pkg::S_MERGE_HI;
      end
      ffha_pkg::S_MERGE_HI: begin
        state_d = ffha_pkg::S_DONE;
        if (idx7 + 7'd1 < count_q && !cu[idxp1]) begin
          ctl.cmd       = ffha_pkg::C_WRITE;
          ctl.pos       = 6'(idx_q);
          ctl.start_val = cs[idx_q];
          ctl.size_val  = 16'(17'(cz[idx_q]) + Hdr + 17'(cz[idxp1]));
          ctl.used_val  = 1'b0;
          state_d = ffha_pkg::S_DROP_HI;
        end else if (idx7 + 7'd1 == count_q) begin
          brk_d   = 17'(cs[idx_q]);
          count_d = count_q - 7'd1;
        end
      end
      ffha_pkg::S_DROP_HI: begin
        ctl.cmd = ffha_pkg::C_DELETE;
        ctl.pos = 6'(idxp1);
        state_d = ffha_pkg::S_DONE;
        // merged block is last once the absorbed one is gone: drop it too
        if (idx7 + 7'd2 == count_q) begin
          brk_d   = 17'(cs[idx_q]);
          count_d = count_q - 7'd2;
        end else begin
          count_d = count_q - 7'd1;
        end
      end
      ffha_pkg::S_DONE: begin
        if (!out_stall_i) state_d = ffha_pkg::S_IDLE;
      end
      default: state_d = ffha_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::S_IDLE;
      count_q <= '0;
      brk_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      brk_q   <= brk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    gaddr_q <= gaddr_d;
    st_q    <= st_d;
  end

  assign in_stall_o        = (state_q != ffha_pkg::S_IDLE);
  assign out_valid_o       = (state_q == ffha_pkg::S_DONE);
  assign granted_address_o = gaddr_q;
  assign status_o          = st_q;
endmodule

// ----- sv/ffha_checker.sv -----
// Port-level checker for the heap allocator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] granted_address_o,
  input logic [2:0]  status_o
);
  logic failed;
  assign failed = out_valid_o && (status_o != ffha_pkg::StOk);

  `ASSERT_IMPL(a_status_range, clk_i, rst_ni, out_valid_o, status_o <= ffha_pkg::StUnknown)
  `ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, failed, granted_address_o == 16'd0)
  `ASSERT_IMPL(a_busy, clk_i, rst_ni, out_valid_o, in_stall_o)
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o))
endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (.*);
